// ===== design/frcd_pkg.sv =====
// Shared types and constants for the FastCGI record deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package frcd_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int HC_W         = 4;
    localparam int LONG_BIT     = 7;

    // record types that get special handling
    localparam logic [7:0] TYPE_BEGIN_REQUEST = 8'd1;
    localparam logic [7:0] TYPE_PARAMS        = 8'd4;
    localparam logic [7:0] TYPE_STDIN         = 8'd5;

    // header byte positions
    localparam logic [HC_W-1:0] HDR_TYPE   = 4'd1;
    localparam logic [HC_W-1:0] HDR_ID_HI  = 4'd2;
    localparam logic [HC_W-1:0] HDR_ID_LO  = 4'd3;
    localparam logic [HC_W-1:0] HDR_LEN_HI = 4'd4;
    localparam logic [HC_W-1:0] HDR_LEN_LO = 4'd5;
    localparam logic [HC_W-1:0] HDR_PAD    = 4'd6;
    localparam logic [HC_W-1:0] HDR_LAST   = 4'd7;

    // word class assigned by the framer
    localparam logic [1:0] CLS_NONE   = 2'd0;
    localparam logic [1:0] CLS_PARAMS = 2'd1;
    localparam logic [1:0] CLS_STDIN  = 2'd2;

    // output kind codes
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_NAME  = 2'd1;
    localparam logic [1:0] KIND_VALUE = 2'd2;
    localparam logic [1:0] KIND_STDIN = 2'd3;

    // pair decoder steps
    localparam logic [1:0] STEP_NAME_LEN  = 2'd0;
    localparam logic [1:0] STEP_VALUE_LEN = 2'd1;
    localparam logic [1:0] STEP_NAME      = 2'd2;
    localparam logic [1:0] STEP_VALUE     = 2'd3;

    // request phase
    localparam logic [1:0] PHASE_IDLE   = 2'd0;
    localparam logic [1:0] PHASE_BEGUN  = 2'd1;
    localparam logic [1:0] PHASE_PARAMS = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int OUT_DEPTH   = 2;
    localparam int OUT_AW      = $clog2(OUT_DEPTH);

    typedef struct packed {
        logic [7:0]  data;
        logic [1:0]  cls;
        logic        complete;
        logic        rec_empty;
        logic [7:0]  rtype;
        logic [15:0] pending_id;
    } token_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic        pair_end;
        logic        record_end;
        logic [7:0]  record_type;
        logic        request_begin;
        logic        params_done;
        logic        request_done;
        logic        param_error;
        logic [15:0] request_id;
        logic [1:0]  phase;
    } result_t;

endpackage

`default_nettype wire

// ===== design/frcd_front.sv =====
// Record framer: collects the 8-byte header and counts content and padding.
// Tags each word with its class and record events. Uses frcd_pkg.
`default_nettype none

module frcd_front
    import frcd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire logic [7:0] rx_byte,
    output logic        full,
    input  wire logic   q_full,
    output logic        q_push,
    output token_t      q_token
);

    logic [HC_W-1:0] hc_reg, hc_next;
    logic [7:0]      type_reg, type_next;
    logic [15:0]     pid_reg, pid_next;
    logic [15:0]     content_reg, content_next;
    logic [7:0]      pad_reg, pad_next;
    logic            empty_reg, empty_next;
    logic            complete;
    logic [1:0]      cls;
    logic            accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        hc_next      = hc_reg;
        type_next    = type_reg;
        pid_next     = pid_reg;
        content_next = content_reg;
        pad_next     = pad_reg;
        empty_next   = empty_reg;
        complete     = 1'b0;
        cls          = CLS_NONE;
        if (hc_reg < HC_W'(HEADER_BYTES))
        begin
            case (hc_reg)
                HDR_TYPE:   type_next = rx_byte;
                HDR_ID_HI:  pid_next = {rx_byte, 8'd0};
                HDR_ID_LO:  pid_next = {pid_reg[15:8], rx_byte};
                HDR_LEN_HI: content_next = {rx_byte, 8'd0};
                HDR_LEN_LO: content_next = {content_reg[15:8], rx_byte};
                HDR_PAD:    pad_next = rx_byte;
                default:    ;
            endcase
            hc_next = hc_reg + 1'b1;
            if (hc_reg == HDR_LAST)
            begin
                empty_next = (content_reg == 16'd0);
                complete   = (content_reg == 16'd0) && (pad_reg == 8'd0);
            end
        end
        else if (content_reg != 16'd0)
        begin
            if (type_reg == TYPE_PARAMS)
                cls = CLS_PARAMS;
            else if (type_reg == TYPE_STDIN)
                cls = CLS_STDIN;
            content_next = content_reg - 1'b1;
            complete     = (content_next == 16'd0) && (pad_reg == 8'd0);
        end
        else
        begin
            if (pad_reg != 8'd0)
                pad_next = pad_reg - 1'b1;
            complete = (pad_next == 8'd0);
        end
        if (complete)
            hc_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg      <= '0;
            type_reg    <= '0;
            pid_reg     <= '0;
            content_reg <= '0;
            pad_reg     <= '0;
            empty_reg   <= 1'b0;
        end
        else if (accept)
        begin
            hc_reg      <= hc_next;
            type_reg    <= type_next;
            pid_reg     <= pid_next;
            content_reg <= content_next;
            pad_reg     <= pad_next;
            empty_reg   <= empty_next;
        end
    end

    assign q_push = accept;

    always_comb
    begin
        q_token.data       = rx_byte;
        q_token.cls        = cls;
        q_token.complete   = complete;
        q_token.rec_empty  = empty_next;
        q_token.rtype      = type_next;
        q_token.pending_id = pid_next;
    end

endmodule

`default_nettype wire

// ===== design/frcd_queue.sv =====
// Short queue of classified words between the framer and the decoder.
// Uses token_t from frcd_pkg.
`default_nettype none

module frcd_queue
    import frcd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire token_t push_token,
    output logic        full,
    input  wire logic   pop,
    output logic        empty,
    output token_t      head
);

    token_t              mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_reg, rd_reg;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_reg <= wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= rd_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= push_token;
    end

endmodule

`default_nettype wire

// ===== design/frcd_back.sv =====
// Pair decoder, request tracking and the result buffer.
// Consumes classified words from frcd_queue; uses frcd_pkg.
`default_nettype none

module frcd_back
    import frcd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_empty,
    input  wire token_t q_head,
    output logic        q_pop,
    input  wire logic   pop,
    output logic        empty,
    output result_t     head
);

    logic [1:0]  step_reg, step_next;
    logic [6:0]  name_reg, name_next;
    logic [6:0]  value_reg, value_next;
    logic        err_reg, err_next;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] id_reg, id_next;
    result_t     res;

    result_t             obuf [OUT_DEPTH];
    logic [OUT_AW-1:0]   owr_reg, ord_reg;
    logic [OUT_AW:0]     ocount_reg;
    logic                out_pop, take;

    assign empty   = (ocount_reg == '0);
    assign out_pop = pop && !empty;
    assign take    = !q_empty &&
                     ((ocount_reg != (OUT_AW+1)'(OUT_DEPTH)) || out_pop);
    assign q_pop   = take;
    assign head    = obuf[ord_reg];

    always_comb
    begin
        step_next  = step_reg;
        name_next  = name_reg;
        value_next = value_reg;
        err_next   = err_reg;
        phase_next = phase_reg;
        id_next    = id_reg;
        res        = '0;

        if (q_head.cls == CLS_STDIN)
            res.kind = KIND_STDIN;
        else if (q_head.cls == CLS_PARAMS && !err_reg)
        begin
            case (step_reg)
                STEP_NAME_LEN:
                begin
                    if (q_head.data[LONG_BIT])
                        err_next = 1'b1;
                    else
                    begin
                        name_next = q_head.data[6:0];
                        step_next = STEP_VALUE_LEN;
                    end
                end
                STEP_VALUE_LEN:
                begin
                    if (q_head.data[LONG_BIT])
                        err_next = 1'b1;
                    else
                    begin
                        value_next = q_head.data[6:0];
                        if (name_reg != 7'd0)
                            step_next = STEP_NAME;
                        else if (q_head.data[6:0] != 7'd0)
                            step_next = STEP_VALUE;
                        else
                        begin
                            step_next    = STEP_NAME_LEN;
                            res.pair_end = 1'b1;
                        end
                    end
                end
                STEP_NAME:
                begin
                    res.kind  = KIND_NAME;
                    name_next = name_reg - 1'b1;
                    if (name_next == 7'd0)
                    begin
                        if (value_reg != 7'd0)
                            step_next = STEP_VALUE;
                        else
                        begin
                            step_next    = STEP_NAME_LEN;
                            res.pair_end = 1'b1;
                        end
                    end
                end
                default:
                begin
                    res.kind   = KIND_VALUE;
                    value_next = value_reg - 1'b1;
                    if (value_next == 7'd0)
                    begin
                        step_next    = STEP_NAME_LEN;
                        res.pair_end = 1'b1;
                    end
                end
            endcase
        end

        // error output shows the flag before any clear by a record event
        res.param_error = err_next;

        if (q_head.complete)
        begin
            res.record_end = 1'b1;
            if (q_head.rtype == TYPE_BEGIN_REQUEST)
            begin
                id_next           = q_head.pending_id;
                phase_next        = PHASE_BEGUN;
                res.request_begin = 1'b1;
            end
            else if (q_head.rtype == TYPE_PARAMS && q_head.rec_empty)
            begin
                phase_next      = PHASE_PARAMS;
                res.params_done = 1'b1;
            end
            else if (q_head.rtype == TYPE_STDIN && q_head.rec_empty)
            begin
                phase_next       = PHASE_IDLE;
                res.request_done = 1'b1;
            end
            if (res.request_begin || res.params_done)
            begin
                step_next  = STEP_NAME_LEN;
                name_next  = '0;
                value_next = '0;
                err_next   = 1'b0;
            end
        end

        res.data_byte   = (res.kind != KIND_NONE) ? q_head.data : 8'd0;
        res.record_type = q_head.rtype;
        res.request_id  = id_next;
        res.phase       = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= STEP_NAME_LEN;
            name_reg   <= '0;
            value_reg  <= '0;
            err_reg    <= 1'b0;
            phase_reg  <= PHASE_IDLE;
            id_reg     <= '0;
            owr_reg    <= '0;
            ord_reg    <= '0;
            ocount_reg <= '0;
        end
        else
        begin
            if (take)
            begin
                step_reg  <= step_next;
                name_reg  <= name_next;
                value_reg <= value_next;
                err_reg   <= err_next;
                phase_reg <= phase_next;
                id_reg    <= id_next;
                owr_reg   <= owr_reg + 1'b1;
            end
            if (out_pop)
                ord_reg <= ord_reg + 1'b1;
            if (take && !out_pop)
                ocount_reg <= ocount_reg + 1'b1;
            else if (out_pop && !take)
                ocount_reg <= ocount_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            obuf[owr_reg] <= res;
    end

endmodule

`default_nettype wire

// ===== design/fastcgi_record_deframer.sv =====
// FastCGI record deframer: one byte word in, one result word out per byte.
// Path: an accepted byte is stored in the queue, then decoded into the result buffer.
// Throughput: one byte per cycle; full rises only when the 4-word queue and
// the 2-word result buffer are both backed up by a stalled reader.
// Reset (rst_n, async, active low) clears framing, decoder, phase and all queues.
// Top level; uses frcd_pkg, frcd_front, frcd_queue, frcd_back.
`default_nettype none

module fastcgi_record_deframer
    import frcd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  rx_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       kind,
    output logic [7:0]       data_byte,
    output logic             pair_end,
    output logic             record_end,
    output logic [7:0]       record_type,
    output logic             request_begin,
    output logic             params_done,
    output logic             request_done,
    output logic             param_error,
    output logic [15:0]      request_id,
    output logic [1:0]       phase
);

    logic    q_full, q_push, q_empty, q_pop;
    token_t  q_in, q_head;
    result_t res;

    frcd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .rx_byte (rx_byte),
        .full    (full),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_token (q_in)
    );

    frcd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_token (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    frcd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .head    (res)
    );

    assign kind          = res.kind;
    assign data_byte     = res.data_byte;
    assign pair_end      = res.pair_end;
    assign record_end    = res.record_end;
    assign record_type   = res.record_type;
    assign request_begin = res.request_begin;
    assign params_done   = res.params_done;
    assign request_done  = res.request_done;
    assign param_error   = res.param_error;
    assign request_id    = res.request_id;
    assign phase         = res.phase;

endmodule

`default_nettype wire

// ===== design/frcd_checker.sv =====
// Port-level checks for fastcgi_record_deframer, attached by bind.
// Uses frcd_pkg codes only.
`default_nettype none

module frcd_checker
    import frcd_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [1:0]  kind,
    input wire logic [7:0]  data_byte,
    input wire logic        record_end,
    input wire logic        request_begin,
    input wire logic        params_done,
    input wire logic        request_done,
    input wire logic [1:0]  phase
);

    a_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_NONE) |-> data_byte == 8'd0)
        else $error("data word without a kind");

    a_begin: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && request_begin) |-> (record_end && phase == PHASE_BEGUN))
        else $error("request begin without record end or phase");

    a_params: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && params_done) |-> (record_end && phase == PHASE_PARAMS))
        else $error("params done without record end or phase");

    a_reqdone: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && request_done) |-> (record_end && phase == PHASE_IDLE))
        else $error("request done without record end or idle phase");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result word dropped");

endmodule

bind fastcgi_record_deframer frcd_checker u_frcd_checker (.*);

`default_nettype wire

// ===== test/tb.sv =====
// Testbench for fastcgi_record_deframer: byte words in, one checked result word out per byte.
// Keeps its own model of the framer and the pair decoder and compares every popped word.
// Depends on frcd_pkg (codes and result_t) and the deframer RTL.
`timescale 1ns / 100ps

module tb;
    import frcd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;
    localparam int RANDOM_BYTES = 280;

    typedef logic [7:0] byte_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        pop;
    logic [7:0]  rx_byte;
    logic        full;
    logic        empty;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        pair_end;
    logic        record_end;
    logic [7:0]  record_type;
    logic        request_begin;
    logic        params_done;
    logic        request_done;
    logic        param_error;
    logic [15:0] request_id;
    logic [1:0]  phase;

    // model state
    logic [HC_W-1:0] hdr_cnt;
    logic [7:0]      cur_type;
    logic [15:0]     pend_id;
    logic [15:0]     content_left;
    logic [7:0]      pad_left;
    logic [15:0]     req_id;
    logic [1:0]      pair_step;
    logic [6:0]      name_left;
    logic [6:0]      value_left;
    logic            err_flag;
    logic [1:0]      req_phase;
    logic            rec_empty;

    result_t decoded_q[$];
    byte_t   body_q[$];
    byte_t   pair_q[$];

    int errors;
    int bytes_sent;
    int words_seen;
    int cycle_cnt;
    bit no_idle;
    bit hold_req;

    fastcgi_record_deframer uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .rx_byte(rx_byte),
        .empty(empty),
        .pop(pop),
        .kind(kind),
        .data_byte(data_byte),
        .pair_end(pair_end),
        .record_end(record_end),
        .record_type(record_type),
        .request_begin(request_begin),
        .params_done(params_done),
        .request_done(request_done),
        .param_error(param_error),
        .request_id(request_id),
        .phase(phase)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT)
            begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [7:0] rand_pad();
        if ($urandom_range(0, 24) == 0)
            return 8'hFF;
        return 8'($urandom_range(0, 7));
    endfunction

    // pair length: mostly short, now and then the longest short form
    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 8'($urandom_range(0, 3));
        if (r < 95)
            return 8'($urandom_range(4, 12));
        return 8'h7F;
    endfunction

    function automatic string fmt_result(input result_t r);
        return $sformatf({"kind %0d data %h pe %b re %b type %h rb %b pd %b rd %b",
                          " err %b id %h ph %0d"},
                         r.kind, r.data_byte, r.pair_end, r.record_end, r.record_type,
                         r.request_begin, r.params_done, r.request_done, r.param_error,
                         r.request_id, r.phase);
    endfunction

    // Advance the framer model by one byte and queue the word it yields.
    task automatic frame_byte(input logic [7:0] b);
        result_t r;
        bit done;
        r = '0;
        done = 1'b0;
        if (hdr_cnt < HC_W'(HEADER_BYTES))
        begin
            case (hdr_cnt)
                HDR_TYPE:   cur_type = b;
                HDR_ID_HI:  pend_id = {b, 8'h00};
                HDR_ID_LO:  pend_id = pend_id | {8'h00, b};
                HDR_LEN_HI: content_left = {b, 8'h00};
                HDR_LEN_LO: content_left = content_left | {8'h00, b};
                HDR_PAD:    pad_left = b;
                default: ;
            endcase
            hdr_cnt++;
            if (hdr_cnt == HC_W'(HEADER_BYTES))
            begin
                rec_empty = (content_left == 16'd0);
                done = (content_left == 16'd0) && (pad_left == 8'd0);
            end
        end
        else if (content_left != 16'd0)
        begin
            if (cur_type == TYPE_PARAMS)
            begin
                // sticky error swallows the rest of the params content
                if (!err_flag)
                begin
                    case (pair_step)
                        STEP_NAME_LEN:
                        begin
                            if (b[LONG_BIT])
                                err_flag = 1'b1;
                            else
                            begin
                                name_left = b[6:0];
                                pair_step = STEP_VALUE_LEN;
                            end
                        end
                        STEP_VALUE_LEN:
                        begin
                            if (b[LONG_BIT])
                                err_flag = 1'b1;
                            else
                            begin
                                value_left = b[6:0];
                                if (name_left != 7'd0)
                                    pair_step = STEP_NAME;
                                else if (value_left != 7'd0)
                                    pair_step = STEP_VALUE;
                                else
                                begin
                                    pair_step = STEP_NAME_LEN;
                                    r.pair_end = 1'b1;
                                end
                            end
                        end
                        STEP_NAME:
                        begin
                            r.kind = KIND_NAME;
                            name_left--;
                            if (name_left == 7'd0)
                            begin
                                if (value_left != 7'd0)
                                    pair_step = STEP_VALUE;
                                else
                                begin
                                    pair_step = STEP_NAME_LEN;
                                    r.pair_end = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            r.kind = KIND_VALUE;
                            value_left--;
                            if (value_left == 7'd0)
                            begin
                                pair_step = STEP_NAME_LEN;
                                r.pair_end = 1'b1;
                            end
                        end
                    endcase
                end
            end
            else if (cur_type == TYPE_STDIN)
                r.kind = KIND_STDIN;
            content_left--;
            done = (content_left == 16'd0) && (pad_left == 8'd0);
        end
        else
        begin
            if (pad_left != 8'd0)
                pad_left--;
            done = (pad_left == 8'd0);
        end

        // error shows its value before any clear on this byte
        r.param_error = err_flag;

        if (done)
        begin
            r.record_end = 1'b1;
            hdr_cnt = '0;
            if (cur_type == TYPE_BEGIN_REQUEST)
            begin
                req_id = pend_id;
                req_phase = PHASE_BEGUN;
                r.request_begin = 1'b1;
            end
            else if (cur_type == TYPE_PARAMS && rec_empty)
            begin
                req_phase = PHASE_PARAMS;
                r.params_done = 1'b1;
            end
            else if (cur_type == TYPE_STDIN && rec_empty)
            begin
                req_phase = PHASE_IDLE;
                r.request_done = 1'b1;
            end
            if (r.request_begin || r.params_done)
            begin
                pair_step = STEP_NAME_LEN;
                name_left = '0;
                value_left = '0;
                err_flag = 1'b0;
            end
        end

        if (r.kind != KIND_NONE)
            r.data_byte = b;
        r.record_type = cur_type;
        r.request_id = req_id;
        r.phase = req_phase;
        decoded_q = {decoded_q, r};
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        frame_byte(b);
        bytes_sent++;
    endtask

    // one record carrying body_q as content, random version, reserved and padding bytes
    task automatic send_record(input logic [7:0] t, input logic [15:0] id,
                               input logic [7:0] pad);
        logic [15:0] len;
        len = 16'(body_q.size());
        send_byte(8'($urandom));
        send_byte(t);
        send_byte(id[15:8]);
        send_byte(id[7:0]);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        send_byte(pad);
        send_byte(8'($urandom));
        while (body_q.size() > 0)
            send_byte(body_q.pop_front());
        repeat (pad) send_byte(8'($urandom));
    endtask

    task automatic fill_body(input int n);
        body_q.delete();
        repeat (n) body_q = {body_q, 8'($urandom)};
    endtask

    // name-value stream; when sloppy, some lengths come in long form
    task automatic build_pairs(input int npairs, input bit sloppy);
        logic [7:0] nl;
        logic [7:0] vl;
        pair_q.delete();
        repeat (npairs)
        begin
            nl = pick_len();
            vl = pick_len();
            if (sloppy && $urandom_range(0, 3) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    pair_q = {pair_q, (8'h80 | 8'($urandom))};
                else
                begin
                    pair_q = {pair_q, nl};
                    pair_q = {pair_q, (8'h80 | 8'($urandom))};
                end
            end
            else
            begin
                pair_q = {pair_q, nl};
                pair_q = {pair_q, vl};
                repeat (nl) pair_q = {pair_q, 8'($urandom)};
                repeat (vl) pair_q = {pair_q, 8'($urandom)};
            end
        end
    endtask

    // begin*, params split across records, params end*, stdin, request end (*sloppy may skip)
    task automatic send_request(input bit sloppy);
        logic [15:0] id;
        int n;
        id = 16'($urandom);
        if (!sloppy || $urandom_range(0, 1) == 0)
        begin
            fill_body(($urandom_range(0, 4) == 0) ? $urandom_range(0, 8) : 8);
            send_record(TYPE_BEGIN_REQUEST, id, rand_pad());
        end
        build_pairs($urandom_range(1, 5), sloppy);
        while (pair_q.size() > 0)
        begin
            n = $urandom_range(1, 24);
            body_q.delete();
            while (n > 0 && pair_q.size() > 0)
            begin
                body_q = {body_q, pair_q.pop_front()};
                n--;
            end
            send_record(TYPE_PARAMS, id, rand_pad());
        end
        body_q.delete();
        if (!sloppy || $urandom_range(0, 1) == 0)
            send_record(TYPE_PARAMS, id, rand_pad());
        repeat ($urandom_range(0, 2))
        begin
            fill_body($urandom_range(1, 30));
            send_record(TYPE_STDIN, id, rand_pad());
        end
        body_q.delete();
        send_record(TYPE_STDIN, id, rand_pad());
    endtask

    // result side: random stalls, plus a long hold when asked
    initial
    begin : result_side
        int stall;
        int hold;
        result_t got;
        result_t want;
        stall = 0;
        hold = 0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                got = {kind, data_byte, pair_end, record_end, record_type, request_begin,
                       params_done, request_done, param_error, request_id, phase};
                if (decoded_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("word %0d: unexpected result %s", words_seen, fmt_result(got));
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("word %0d: mismatch", words_seen);
                            $display("  expected %s", fmt_result(want));
                            $display("  actual   %s", fmt_result(got));
                        end
                    end
                end
                words_seen++;
            end
            if (hold_req)
            begin
                hold = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold > 0)
            begin
                hold--;
                pop <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    // empty record completing on the reserved byte, all-ones id
    task automatic test_begin_request;
        body_q.delete();
        send_record(TYPE_BEGIN_REQUEST, 16'hFFFF, 8'd0);
    endtask

    // empty pair, name-only pair, long-form length, then params end clears the error
    task automatic test_param_pairs;
        body_q = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h41, 8'h80, 8'h12};
        send_record(TYPE_PARAMS, 16'h0000, 8'd1);
        body_q.delete();
        send_record(TYPE_PARAMS, 16'h0000, 8'd0);
    endtask

    // stdin bytes, an unknown type with padding, then request end
    task automatic test_stdin_flow;
        body_q = '{8'h00, 8'hFF};
        send_record(TYPE_STDIN, 16'h8001, 8'd0);
        body_q = '{8'h5A};
        send_record(8'hFF, 16'h7FFE, 8'd2);
        body_q.delete();
        send_record(TYPE_STDIN, 16'h0001, 8'd0);
    endtask

    task automatic test_full_rate;
        no_idle = 1'b1;
        send_request(1'b0);
        no_idle = 1'b0;
    endtask

    // reader holds off while words keep coming, so the block backs up and raises full
    task automatic test_backpressure;
        hold_req = 1'b1;
        no_idle = 1'b1;
        fill_body(24);
        send_record(TYPE_STDIN, 16'h1234, 8'd3);
        no_idle = 1'b0;
    endtask

    task automatic test_random_stream;
        int start;
        int sel;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 75)
                send_request(1'b0);
            else if (sel < 85)
                send_request(1'b1);
            else if (sel < 93)
            begin
                // stray record of any type, content is noise
                fill_body($urandom_range(0, 12));
                send_record(($urandom_range(0, 1) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, 11)),
                            16'($urandom), rand_pad());
            end
            else if (sel < 98)
            begin
                // empty params or stdin out of order
                body_q.delete();
                send_record(($urandom_range(0, 1) == 0) ? TYPE_PARAMS : TYPE_STDIN,
                            16'($urandom), rand_pad());
            end
            else
            begin
                // content length with a nonzero high byte
                fill_body($urandom_range(256, 300));
                send_record(($urandom_range(0, 1) == 0) ? TYPE_PARAMS : TYPE_STDIN,
                            16'($urandom), rand_pad());
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        rx_byte = 8'd0;
        errors = 0;
        bytes_sent = 0;
        words_seen = 0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        hdr_cnt = '0;
        cur_type = '0;
        pend_id = '0;
        content_left = '0;
        pad_left = '0;
        req_id = '0;
        pair_step = STEP_NAME_LEN;
        name_left = '0;
        value_left = '0;
        err_flag = 1'b0;
        req_phase = PHASE_IDLE;
        rec_empty = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_begin_request();
        test_param_pairs();
        test_stdin_flow();
        test_full_rate();
        test_backpressure();
        test_random_stream();

        push <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0 && decoded_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
